[rtl/core/mlfq_pkg.sv]
// Shared types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

    localparam int unsigned MaxTasksDefault = 64;
    localparam int unsigned TimeBitsDefault = 32;
    localparam int unsigned NumLevels       = 3;

    localparam logic [7:0]  Quantum0Reset = 8'd8;
    localparam logic [7:0]  Quantum1Reset = 8'd16;
    localparam logic [15:0] AgingReset    = 16'd50;
    localparam logic [7:0]  QuantumSat    = 8'd255;

    localparam logic [1:0] RegQuantum0 = 2'd0;
    localparam logic [1:0] RegQuantum1 = 2'd1;
    localparam logic [1:0] RegAging    = 2'd2;

    localparam logic OpArrive = 1'b0;
    localparam logic OpTick   = 1'b1;

    localparam logic [2:0] StIdle     = 3'd0;
    localparam logic [2:0] StRan      = 3'd1;
    localparam logic [2:0] StDone     = 3'd2;
    localparam logic [2:0] StAccepted = 3'd3;
    localparam logic [2:0] StRejected = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  task_id;
        logic [15:0] burst_length;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  run_task;
        logic [1:0]  run_level;
        logic [31:0] completion_time;
        logic [31:0] turnaround_time;
        logic [31:0] waiting_time;
    } out_word_t;

endpackage

[rtl/core/multilevel_feedback_queue_scheduler.sv]
// Top level of the three-level feedback queue scheduler with aging.
// Path from an accepted word to its result: an arrival passes S_ARR, an idle tick passes
// S_HEAD, and a tick that runs a task passes S_HEAD, S_TASK and S_EXEC (queue head read,
// task entry read, update); a tick that ages first runs S_AGERD and S_AGEWR for each task moved.
// One word at a time: the next word can be accepted in the cycle after the result is taken.
// Reset clears time, levels and active flags and loads the register defaults.
module multilevel_feedback_queue_scheduler #(
    parameter int unsigned MAX_TASKS = mlfq_pkg::MaxTasksDefault,
    parameter int unsigned TIME_BITS = mlfq_pkg::TimeBitsDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mlfq_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mlfq_pkg::out_word_t  out_word
);
    import mlfq_pkg::*;

    localparam int unsigned IW = $clog2(MAX_TASKS);
    localparam int unsigned QD = NumLevels * MAX_TASKS;
    localparam int unsigned QW = $clog2(QD);
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    // Task entry: remaining, burst, arrival, quantum used.
    localparam int unsigned EW = 16 + 16 + TIME_BITS + 8;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_AGERD = 8'b00000010,
        S_AGEWR = 8'b00000100,
        S_HEAD  = 8'b00001000,
        S_TASK  = 8'b00010000,
        S_EXEC  = 8'b00100000,
        S_ARR   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0]  q0_reg, q1_reg;
    logic [15:0] period_reg, countdown_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [MAX_TASKS-1:0] active_reg;
    logic [IW-1:0] head_reg [NumLevels];
    logic [CW-1:0] count_reg [NumLevels];
    in_word_t  in_reg;
    out_word_t out_reg;
    logic [1:0]  lv_reg;
    logic [IW-1:0] id_reg;
    logic [1:0]  age_lv_reg;

    // Memories: the queue store and the task table.
    logic          q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    logic [5:0]    q_wdata, q_rdata;
    logic          t_we;
    logic [IW-1:0] t_waddr, t_raddr;
    logic [EW-1:0] t_wdata, t_rdata;

    mlfq_ram #(.WIDTH(6), .DEPTH(QD)) u_qram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    mlfq_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_tram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    function automatic logic [QW-1:0] qaddr(input logic [1:0] lv, input logic [IW-1:0] ix);
        qaddr = QW'(32'(lv) * MAX_TASKS + 32'(ix));
    endfunction

    // Ring pointer step; the ring holds MAX_TASKS entries per level.
    function automatic logic [IW-1:0] next_ptr(input logic [IW-1:0] p);
        next_ptr = (p == IW'(MAX_TASKS - 1)) ? '0 : p + IW'(1);
    endfunction

    // Free slot behind the last entry of a level.
    function automatic logic [IW-1:0] tail_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] cnt);
        logic [IW:0] sum;
        sum = {1'b0, head} + (IW+1)'(cnt);
        if (sum >= (IW+1)'(MAX_TASKS))
            sum = sum - (IW+1)'(MAX_TASKS);
        tail_of = sum[IW-1:0];
    endfunction

    // Result word with only a status and a task number set.
    function automatic out_word_t status_word(input logic [2:0] st, input logic [5:0] tid);
        status_word = '0;
        status_word.status = st;
        status_word.run_task = tid;
    endfunction

    logic [IW-1:0] tail0;
    logic [1:0] sel_lv;
    logic any_ready;
    logic [15:0] t_rem, t_burst, rem_dec;
    logic [TIME_BITS-1:0] t_arr, time_inc;
    logic [7:0] t_used, used_inc, quantum;
    logic        id_ok;
    logic        arr_ok;

    assign tail0 = tail_of(head_reg[0], count_reg[0]);
    assign {t_rem, t_burst, t_arr, t_used} = t_rdata;
    assign rem_dec  = (t_rem != 16'd0) ? t_rem - 16'd1 : t_rem;
    assign time_inc = time_reg + TIME_BITS'(1);
    assign used_inc = (t_used != QuantumSat) ? t_used + 8'd1 : t_used;
    assign quantum  = (lv_reg == 2'd0) ? q0_reg : q1_reg;
    assign id_ok    = (32'(in_reg.task_id) < MAX_TASKS);
    // An arrival is taken only for a free slot and a nonzero burst.
    assign arr_ok   = id_ok && !active_reg[IW'(in_reg.task_id)] &&
                      in_reg.burst_length != 16'd0;

    always_comb
    begin
        any_ready = 1'b1;
        sel_lv = 2'd0;
        if (count_reg[0] != '0)      sel_lv = 2'd0;
        else if (count_reg[1] != '0) sel_lv = 2'd1;
        else if (count_reg[2] != '0) sel_lv = 2'd2;
        else                         any_ready = 1'b0;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_word  = out_reg;

    // Memory port control.
    always_comb
    begin
        q_we = 1'b0; q_waddr = qaddr(2'd0, tail0); q_wdata = 6'(id_reg);
        q_raddr = qaddr(sel_lv, head_reg[sel_lv]);
        t_we = 1'b0; t_waddr = id_reg; t_wdata = t_rdata;
        t_raddr = id_reg;
        unique case (state_reg)
            S_AGERD:
            begin
                // The queue word read in the first aging step addresses the
                // task table in the second one.
                q_raddr = qaddr(age_lv_reg, head_reg[age_lv_reg]);
                t_raddr = IW'(q_rdata);
            end
            S_AGEWR:
            begin
                q_we = 1'b1; q_wdata = q_rdata;
                t_we = 1'b1; t_waddr = IW'(q_rdata);
                t_wdata = {t_rem, t_burst, t_arr, 8'd0};
            end
            S_HEAD: ;
            S_TASK: t_raddr = IW'(q_rdata);
            S_EXEC:
            begin
                t_we = 1'b1;
                if (rem_dec != 16'd0 && lv_reg != 2'd2)
                begin
                    t_wdata = {rem_dec, t_burst, t_arr,
                               (used_inc >= quantum) ? 8'd0 : used_inc};
                    if (used_inc >= quantum)
                    begin
                        q_we = 1'b1;
                        q_waddr = qaddr(lv_reg + 2'd1, tail_of(head_reg[lv_reg + 2'd1],
                                                               count_reg[lv_reg + 2'd1]));
                    end
                end
                else
                begin
                    t_wdata = {rem_dec, t_burst, t_arr, t_used};
                end
            end
            S_ARR:
            begin
                t_waddr = IW'(in_reg.task_id);
                t_wdata = {in_reg.burst_length, in_reg.burst_length,
                           time_reg, 8'd0};
                if (arr_ok)
                begin
                    t_we = 1'b1; q_we = 1'b1; q_wdata = in_reg.task_id;
                end
            end
            default: ;
        endcase
    end

    // Aging moves one task at a time: read the queue head, read the task
    // entry at that queue word, then write the entry with its quantum count
    // cleared and append the task to level 0.
    logic age_entry_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            q0_reg <= Quantum0Reset; q1_reg <= Quantum1Reset;
            period_reg <= AgingReset; countdown_reg <= AgingReset;
            time_reg <= '0; active_reg <= '0;
            for (int i = 0; i < NumLevels; i++)
            begin
                head_reg[i] <= '0; count_reg[i] <= '0;
            end
            age_lv_reg <= 2'd1;
            age_entry_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegQuantum0: q0_reg <= cfg_data[7:0];
                    RegQuantum1: q1_reg <= cfg_data[7:0];
                    RegAging:    period_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_word.opcode == OpTick && countdown_reg == 16'd0)
                    begin
                        countdown_reg <= period_reg;
                        // Start with the first non-empty lower level.
                        age_lv_reg <= (count_reg[1] != '0) ? 2'd1 : 2'd2;
                    end
                end
                S_AGERD: age_entry_pending_reg <= 1'b1;
                S_AGEWR:
                begin
                    age_entry_pending_reg <= 1'b0;
                    head_reg[age_lv_reg] <= next_ptr(head_reg[age_lv_reg]);
                    count_reg[age_lv_reg] <= count_reg[age_lv_reg] - CW'(1);
                    if (count_reg[0] != CW'(MAX_TASKS))
                        count_reg[0] <= count_reg[0] + CW'(1);
                    if (count_reg[age_lv_reg] == CW'(1))
                        age_lv_reg <= age_lv_reg + 2'd1;
                end
                S_HEAD:
                begin
                    time_reg <= time_inc;
                    countdown_reg <= countdown_reg - 16'd1;
                end
                S_EXEC:
                begin
                    if (rem_dec == 16'd0)
                    begin
                        head_reg[lv_reg] <= next_ptr(head_reg[lv_reg]);
                        count_reg[lv_reg] <= count_reg[lv_reg] - CW'(1);
                        active_reg[id_reg] <= 1'b0;
                    end
                    else if (lv_reg != 2'd2 && used_inc >= quantum)
                    begin
                        head_reg[lv_reg] <= next_ptr(head_reg[lv_reg]);
                        count_reg[lv_reg] <= count_reg[lv_reg] - CW'(1);
                        count_reg[lv_reg + 2'd1] <= count_reg[lv_reg + 2'd1] + CW'(1);
                    end
                end
                S_ARR:
                begin
                    if (arr_ok)
                    begin
                        active_reg[IW'(in_reg.task_id)] <= 1'b1;
                        if (count_reg[0] != CW'(MAX_TASKS))
                            count_reg[0] <= count_reg[0] + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Per task, S_AGERD reads the queue head and then, with the pending flag
    // set, the task entry. S_AGEWR then writes both.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    if (in_word.opcode == OpArrive)
                        state_next = S_ARR;
                    else if (countdown_reg == 16'd0 && (count_reg[1] != '0 || count_reg[2] != '0))
                        state_next = S_AGERD;
                    else
                        state_next = S_HEAD;
                end
            S_AGERD:
                if (count_reg[age_lv_reg] == '0)
                    state_next = (age_lv_reg == 2'd1 && count_reg[2] != '0) ? S_AGERD : S_HEAD;
                else if (age_entry_pending_reg)
                    state_next = S_AGEWR;
            S_AGEWR:
                state_next = (count_reg[age_lv_reg] == CW'(1) &&
                              (age_lv_reg == 2'd2 || count_reg[2] == '0)) ? S_HEAD : S_AGERD;
            S_HEAD:  state_next = any_ready ? S_TASK : S_OUT;
            S_TASK:  state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_ARR:   state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            in_reg <= in_word;
        if (state_reg == S_HEAD)
        begin
            lv_reg <= sel_lv;
            out_reg <= status_word(StIdle, 6'd0);
        end
        if (state_reg == S_TASK)
            id_reg <= IW'(q_rdata);
        if (state_reg == S_EXEC)
        begin
            out_reg.run_task <= 6'(id_reg);
            out_reg.run_level <= lv_reg;
            if (rem_dec == 16'd0)
            begin
                // Times are reported modulo 2^32.
                out_reg.status <= StDone;
                out_reg.completion_time <= 32'(time_reg);
                out_reg.turnaround_time <= 32'(time_reg) - 32'(t_arr);
                out_reg.waiting_time <= 32'(time_reg) - 32'(t_arr) - 32'(t_burst);
            end
            else
                out_reg.status <= StRan;
        end
        if (state_reg == S_ARR)
            out_reg <= status_word(arr_ok ? StAccepted : StRejected, in_reg.task_id);
    end
endmodule

[rtl/core/mlfq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module mlfq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sim/tb.sv]
// Self-checking testbench for the three-level feedback queue scheduler with aging.
module tb;
    import mlfq_pkg::*;

    // The scheduler takes one word at a time and produces one result word for
    // each one. The model below keeps its own copy of the queues and task
    // table and works out the expected result for every accepted word.

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_word;

    multilevel_feedback_queue_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    localparam int NumTasks = 64;

    // Scheduler model state.
    logic [7:0]  sched_q0;
    logic [7:0]  sched_q1;
    logic [15:0] sched_aging;
    logic [31:0] sched_now;
    logic [15:0] sched_countdown;
    bit          slot_busy [NumTasks];
    logic [15:0] slot_left [NumTasks];
    logic [15:0] slot_burst [NumTasks];
    logic [31:0] slot_arrival [NumTasks];
    logic [7:0]  slot_used [NumTasks];
    int          level_queue [3][$];

    out_word_t   expected_words [$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;

    always #5 clk = ~clk;

    // Work out the result of one word and update the model.
    function automatic out_word_t schedule_word(in_word_t w);
        out_word_t   r;
        int          lv;
        int          id;
        logic [31:0] turn;
        logic [7:0]  q;
        r = '0;
        if (w.opcode == OpArrive) begin
            r.run_task = w.task_id;
            id = int'(w.task_id);
            if (slot_busy[id] || w.burst_length == 16'd0) begin
                r.status = StRejected;
                return r;
            end
            slot_busy[id] = 1;
            slot_left[id] = w.burst_length;
            slot_burst[id] = w.burst_length;
            slot_arrival[id] = sched_now;
            slot_used[id] = 8'd0;
            level_queue[0] = {level_queue[0], id};
            r.status = StAccepted;
            return r;
        end
        // Aging moves levels 1 and 2 back to the tail of level 0, in order.
        if (sched_countdown == 16'd0) begin
            for (int l = 1; l < 3; l++)
            begin
                while (level_queue[l].size() != 0)
                begin
                    id = level_queue[l].pop_front();
                    slot_used[id] = 8'd0;
                    level_queue[0] = {level_queue[0], id};
                end
            end
            sched_countdown = sched_aging;
        end
        lv = 3;
        for (int l = 2; l >= 0; l--)
            if (level_queue[l].size() != 0)
                lv = l;
        sched_now = sched_now + 32'd1;
        sched_countdown = sched_countdown - 16'd1;
        r.status = StIdle;
        if (lv == 3)
            return r;
        id = level_queue[lv][0];
        r.run_task = 6'(id);
        r.run_level = 2'(lv);
        if (slot_left[id] != 16'd0)
            slot_left[id] = slot_left[id] - 16'd1;
        if (slot_left[id] == 16'd0) begin
            turn = sched_now - slot_arrival[id];
            void'(level_queue[lv].pop_front());
            slot_busy[id] = 0;
            r.status = StDone;
            r.completion_time = sched_now;
            r.turnaround_time = turn;
            r.waiting_time = turn - 32'(slot_burst[id]);
            return r;
        end
        r.status = StRan;
        if (lv < 2) begin
            q = (lv == 0) ? sched_q0 : sched_q1;
            if (slot_used[id] != QuantumSat)
                slot_used[id] = slot_used[id] + 8'd1;
            // A zero quantum register behaves like one.
            if (slot_used[id] >= q) begin
                void'(level_queue[lv].pop_front());
                slot_used[id] = 8'd0;
                level_queue[lv + 1] = {level_queue[lv + 1], id};
            end
        end
        return r;
    endfunction

    // Send one word, idling first as the current phase asks. The scheduler
    // never takes a word in the cycle right after an acceptance, so valid is
    // dropped for that cycle.
    task automatic send_word(logic op, logic [5:0] id, logic [15:0] burst);
        in_word_t w;
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        w.opcode = op;
        w.task_id = id;
        w.burst_length = burst;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_words = {expected_words, schedule_word(w)};
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic tick_word();
        send_word(OpTick, 6'($urandom), 16'($urandom));
    endtask

    // Wait until every result is in, then allow for a long aging drain.
    task automatic drain();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            RegQuantum0: sched_q0 = val[7:0];
            RegQuantum1: sched_q1 = val[7:0];
            default:     sched_aging = val;
        endcase
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", out_word);
                errors++;
            end
            else begin
                e = expected_words.pop_front();
                if (out_word.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, out_word.status);
                    errors++;
                end
                if (out_word.run_task !== e.run_task) begin
                    $error("run_task: expected %0d, got %0d", e.run_task, out_word.run_task);
                    errors++;
                end
                if (out_word.run_level !== e.run_level) begin
                    $error("run_level: expected %0d, got %0d", e.run_level,
                        out_word.run_level);
                    errors++;
                end
                if (out_word.completion_time !== e.completion_time) begin
                    $error("completion_time: expected %0d, got %0d", e.completion_time,
                        out_word.completion_time);
                    errors++;
                end
                if (out_word.turnaround_time !== e.turnaround_time) begin
                    $error("turnaround_time: expected %0d, got %0d", e.turnaround_time,
                        out_word.turnaround_time);
                    errors++;
                end
                if (out_word.waiting_time !== e.waiting_time) begin
                    $error("waiting_time: expected %0d, got %0d", e.waiting_time,
                        out_word.waiting_time);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls, redrawn every cycle.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Directed: extremes of id and burst, rejections, idle tick, completion.
    task automatic test_directed();
        tick_word();
        send_word(OpArrive, 6'd0, 16'd1);
        send_word(OpArrive, 6'd63, 16'hFFFF);
        send_word(OpArrive, 6'd63, 16'd5);
        send_word(OpArrive, 6'd5, 16'd0);
        send_word(OpArrive, 6'd42, 16'd3);
        repeat (6) tick_word();
        send_word(OpArrive, 6'd0, 16'd2);
        repeat (4) tick_word();
    endtask

    // Random mix of arrivals and ticks; mostly small bursts so tasks finish.
    task automatic test_random(int n);
        logic [15:0] b;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(9))
                    0:       b = 16'($urandom);
                    1:       b = 16'd0;
                    default: b = 16'($urandom_range(40, 1));
                endcase
                send_word(OpArrive, 6'($urandom), b);
            end
            else
                tick_word();
        end
    endtask

    // Send 100 tick words to run down the tasks left in the queues.
    task automatic test_flush();
        for (int k = 0; k < 100; k++)
            tick_word();
    endtask

    // Register settings with extremes, including zero quantums and aging period.
    task automatic test_settings();
        write_reg(RegQuantum0, 16'd1);
        write_reg(RegQuantum1, 16'd255);
        write_reg(RegAging, 16'd1);
        test_random(120);
        write_reg(RegQuantum0, 16'd255);
        write_reg(RegQuantum1, 16'd1);
        write_reg(RegAging, 16'hFFFF);
        test_random(120);
        write_reg(RegQuantum0, 16'hFF00);
        write_reg(RegQuantum1, 16'h0000);
        write_reg(RegAging, 16'd0);
        test_random(120);
        write_reg(RegQuantum0, 16'd3);
        write_reg(RegQuantum1, 16'd5);
        write_reg(RegAging, 16'd7);
        test_random(120);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        in_word = '0;
        out_ready = 0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sched_q0 = Quantum0Reset;
        sched_q1 = Quantum1Reset;
        sched_aging = AgingReset;
        sched_now = 0;
        sched_countdown = AgingReset;
        for (int k = 0; k < NumTasks; k++)
            slot_busy[k] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100);
        send_idle_pct = 58;
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        test_random(100);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_settings();
        test_flush();

        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
